// File: sv/grid_total_variation_top_macros.svh
// assertion macros used by the grid total variation controller
`ifndef GRID_TOTAL_VARIATION_TOP_MACROS_SVH
`define GRID_TOTAL_VARIATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GTV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GTV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GTV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GTV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/gtv_pkg.sv
// shared types, constants and helpers for the grid total variation block
package gtv_pkg;

    localparam logic [1:0] CFG_RADIAL  = 2'd0;
    localparam logic [1:0] CFG_LAT     = 2'd1;
    localparam logic [1:0] CFG_AZIMUTH = 2'd2;

    localparam int SUM_W  = 48;
    localparam int DVD_W  = 49;
    localparam int SQ_W   = 36;
    localparam int ROOT_W = 18;
    localparam int OUT_W  = 17;
    localparam int SQRT_STEPS = SQ_W / 2;

    typedef enum logic [1:0] {
        RD_BASE,
        RD_LAT,
        RD_AZ
    } t_rd_sel;

    typedef struct packed {
        logic    in_take;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_base;
        logic    cap_lat;
        logic    cap_az;
        logic    dif;
        logic    mul;
        logic    sq_init;
        logic    sq_step;
        logic    acc;
        logic    wr;
        logic    adv;
        logic    tot1;
        logic    tot2;
        logic    div_init;
        logic    div_step;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic interior;
        logic last;
        logic out_free;
    } t_status;

    function automatic int eff_count(int v, int maxv);
        int res;
        if (v < 2) begin
            res = 2;
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: sv/gtv_ram.sv
// generic single port ram with registered read
module gtv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/gtv_datapath.sv
// datapath: config, positions, plane store, root, sum and mean divider
module gtv_datapath import gtv_pkg::*; #(
    parameter int MAX_RADIAL  = 64,
    parameter int MAX_LAT     = 64,
    parameter int MAX_AZIMUTH = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic signed [15:0]  i_sample,
    input  logic                i_frame_start,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [OUT_W-1:0]    o_mean_variation,
    input  t_cmd                i_cmd,
    output t_status             o_status
);
    localparam int PW_R = $clog2(MAX_RADIAL);
    localparam int PW_L = $clog2(MAX_LAT);
    localparam int PW_A = $clog2(MAX_AZIMUTH);
    localparam int CW_R = $clog2(MAX_RADIAL + 1);
    localparam int CW_L = $clog2(MAX_LAT + 1);
    localparam int CW_A = $clog2(MAX_AZIMUTH + 1);
    localparam int NW   = CW_R + CW_L + CW_A;
    localparam int DEPTH = MAX_LAT * MAX_AZIMUTH;
    localparam int AW   = $clog2(DEPTH);

    logic [6:0] r_cfg_radial;
    logic [6:0] r_cfg_lat;
    logic [7:0] r_cfg_az;

    logic [CW_R-1:0] nr;
    logic [CW_L-1:0] nl;
    logic [CW_A-1:0] na;

    logic [PW_R-1:0] r_rpos;
    logic [PW_L-1:0] r_lpos;
    logic [PW_A-1:0] r_apos;
    logic [SUM_W-1:0] r_sum;
    logic signed [15:0] r_sample;
    logic signed [15:0] r_base, r_nlat, r_naz;
    logic signed [16:0] r_dr, r_dt, r_dp;
    logic [33:0] r_q0, r_q1, r_q2;
    logic [SQ_W-1:0] r_x, r_r, r_bit;
    logic [SQ_W-1:0] trial_sq;
    logic [ROOT_W-1:0] root;
    logic [CW_R+CW_L-1:0] r_tot1;
    logic [NW-1:0] r_tot;
    logic [DVD_W-1:0] r_dvd, r_quo;
    logic [NW-1:0] r_rem;
    logic [NW:0] trial_dv;
    logic r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic [AW-1:0] addr_here, ram_addr;
    logic [15:0] ram_rdata;

    assign nr = CW_R'(eff_count(int'(r_cfg_radial), MAX_RADIAL));
    assign nl = CW_L'(eff_count(int'(r_cfg_lat), MAX_LAT));
    assign na = CW_A'(eff_count(int'(r_cfg_az), MAX_AZIMUTH));

    assign addr_here = AW'(r_lpos) * AW'(MAX_AZIMUTH) + AW'(r_apos);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_LAT:  ram_addr = addr_here + AW'(MAX_AZIMUTH);
            RD_AZ:   ram_addr = addr_here + AW'(1);
            default: ram_addr = addr_here;
        endcase
        if (i_cmd.wr) begin
            ram_addr = addr_here;
        end
    end

    gtv_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_plane (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_addr  (ram_addr),
        .i_wdata (r_sample),
        .o_rdata (ram_rdata)
    );

    assign o_status.interior = (r_rpos != '0) && (int'(r_lpos) + 1 < int'(nl))
                               && (int'(r_apos) + 1 < int'(na));
    assign o_status.last = (int'(r_rpos) + 1 >= int'(nr)) && (int'(r_lpos) + 1 >= int'(nl))
                           && (int'(r_apos) + 1 >= int'(na));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign trial_sq = r_r + r_bit;
    assign root = (r_x > r_r) ? ROOT_W'(r_r + SQ_W'(1)) : ROOT_W'(r_r);
    assign trial_dv = {r_rem, r_dvd[DVD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_radial <= 7'd64;
            r_cfg_lat    <= 7'd64;
            r_cfg_az     <= 8'd128;
            r_rpos       <= '0;
            r_lpos       <= '0;
            r_apos       <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RADIAL:  r_cfg_radial <= i_cfg_data[6:0];
                    CFG_LAT:     r_cfg_lat    <= i_cfg_data[6:0];
                    CFG_AZIMUTH: r_cfg_az     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.in_take && i_frame_start) begin
                r_rpos <= '0;
                r_lpos <= '0;
                r_apos <= '0;
                r_sum  <= '0;
            end
            if (i_cmd.acc) begin
                r_sum <= r_sum + SUM_W'(root);
            end
            if (i_cmd.adv) begin
                if (o_status.last) begin
                    r_rpos <= '0;
                    r_lpos <= '0;
                    r_apos <= '0;
                    r_sum  <= '0;
                end else if (int'(r_apos) + 1 >= int'(na)) begin
                    r_apos <= '0;
                    if (int'(r_lpos) + 1 >= int'(nl)) begin
                        r_lpos <= '0;
                        r_rpos <= r_rpos + PW_R'(1);
                    end else begin
                        r_lpos <= r_lpos + PW_L'(1);
                    end
                end else begin
                    r_apos <= r_apos + PW_A'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_sample <= i_sample;
        end
        if (i_cmd.cap_base) begin
            r_base <= ram_rdata;
        end
        if (i_cmd.cap_lat) begin
            r_nlat <= ram_rdata;
        end
        if (i_cmd.cap_az) begin
            r_naz <= ram_rdata;
        end
        if (i_cmd.dif) begin
            r_dr <= 17'(r_sample) - 17'(r_base);
            r_dt <= 17'(r_nlat) - 17'(r_base);
            r_dp <= 17'(r_naz) - 17'(r_base);
        end
        if (i_cmd.mul) begin
            r_q0 <= 34'(r_dr) * 34'(r_dr);
            r_q1 <= 34'(r_dt) * 34'(r_dt);
            r_q2 <= 34'(r_dp) * 34'(r_dp);
        end
        if (i_cmd.sq_init) begin
            r_x   <= SQ_W'(r_q0) + SQ_W'(r_q1) + SQ_W'(r_q2);
            r_r   <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end
        if (i_cmd.sq_step) begin
            // one result bit per step
            if (r_x >= trial_sq) begin
                r_x <= r_x - trial_sq;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.tot1) begin
            r_tot1 <= (CW_R + CW_L)'(nr) * (CW_R + CW_L)'(nl);
        end
        if (i_cmd.tot2) begin
            r_tot <= NW'(r_tot1) * NW'(na);
        end
        if (i_cmd.div_init) begin
            // rounded mean: add half the point count before dividing
            r_dvd <= DVD_W'(r_sum) + DVD_W'(r_tot >> 1);
            r_rem <= '0;
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            if (trial_dv >= {1'b0, r_tot}) begin
                r_rem <= NW'(trial_dv - {1'b0, r_tot});
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= trial_dv[NW-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
            r_dvd <= r_dvd << 1;
        end
        if (i_cmd.out_load) begin
            r_out_data <= (|r_quo[DVD_W-1:OUT_W]) ? {OUT_W{1'b1}} : r_quo[OUT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mean_variation = r_out_data;
endmodule

// File: sv/gtv_ctrl.sv
// controller: sequences reads, root steps, store write and mean division
`include "grid_total_variation_top_macros.svh"
module gtv_ctrl import gtv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_RB, S_RT, S_RP, S_CP, S_DIF, S_MUL, S_SQI, S_SQ,
        S_ACC, S_WR, S_T1, S_T2, S_DVI, S_DV, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd = '0;
        o_cmd.rd_sel = RD_BASE;
        n_state = r_state;
        n_cnt = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: n_state = i_status.interior ? S_RB : S_WR;
            S_RB: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_RT;
            end
            S_RT: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_sel = RD_LAT;
                o_cmd.cap_base = 1'b1;
                n_state = S_RP;
            end
            S_RP: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_sel = RD_AZ;
                o_cmd.cap_lat = 1'b1;
                n_state = S_CP;
            end
            S_CP: begin
                o_cmd.cap_az = 1'b1;
                n_state = S_DIF;
            end
            S_DIF: begin
                o_cmd.dif = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_SQI;
            end
            S_SQI: begin
                o_cmd.sq_init = 1'b1;
                n_cnt = 6'(SQRT_STEPS - 1);
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                if (i_status.last) begin
                    n_state = S_T1;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_T1: begin
                o_cmd.tot1 = 1'b1;
                n_state = S_T2;
            end
            S_T2: begin
                o_cmd.tot2 = 1'b1;
                n_state = S_DVI;
            end
            S_DVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt = 6'(DVD_W - 1);
                n_state = S_DV;
            end
            S_DV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output register to free up
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.adv = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `GTV_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_cmd.out_load, i_status.out_free, "result loaded over a pending beat")
    `GTV_ASSERT_NXT(a_accept_chk, i_clk, i_rst_n, accept, r_state == S_CHK, "accepted beat not checked")
    `GTV_ASSERT_NXT(a_div_done, i_clk, i_rst_n, (r_state == S_DV) && (r_cnt == '0), r_state == S_OUT, "divider did not finish")
    `GTV_ASSERT_IMP(a_wr_alone, i_clk, i_rst_n, o_cmd.wr, !o_cmd.rd_en && !o_cmd.acc, "store write overlaps a read")
endmodule

// File: sv/grid_total_variation_top.sv
// grid total variation top level: controller plus datapath
// a sample with no base point goes straight to the store write; an interior one
// first runs the root; a field's last sample adds point count and 49-step divide
// throughput: one sample at a time, set by the 18-step square root loop
// the output register holds a result while the next sample is processed
// synchronous active-low reset: counters and sum clear, counts return to 64/64/128
module grid_total_variation_top import gtv_pkg::*; #(
    parameter int MAX_RADIAL  = 64,
    parameter int MAX_LAT     = 64,
    parameter int MAX_AZIMUTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_sample,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OUT_W-1:0]   o_mean_variation
);
    t_cmd    cmd;
    t_status status;

    gtv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gtv_datapath #(
        .MAX_RADIAL  (MAX_RADIAL),
        .MAX_LAT     (MAX_LAT),
        .MAX_AZIMUTH (MAX_AZIMUTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample         (i_sample),
        .i_frame_start    (i_frame_start),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_mean_variation (o_mean_variation),
        .i_cmd            (cmd),
        .o_status         (status)
    );
endmodule
